[rtl/assert_macros.svh]
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check prop at every rising clock edge, ignored while reset is low.
`define ASSERT_CLK(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Check that cond at one edge implies prop at the next edge.
`define ASSERT_NEXT(lbl, clk, rstn, cond, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (cond) |=> (prop)) else $error(msg);

`endif

[rtl/v2dce_pkg.sv]
// Package of the convolution engine: widths, codes, states and cell control.
package v2dce_pkg;

  localparam int KERNEL_MAX_DEF = 31;
  localparam int LINE_MAX_DEF   = 2048;
  localparam int PIXEL_BITS_DEF = 16;
  localparam int TAP_BITS_DEF   = 16;

  localparam int KS_CFG_W   = 5;
  localparam int OW_W       = 12;
  localparam int OH_W       = 15;
  localparam int OX_W       = 11;
  localparam int OY_W       = 14;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 15;
  localparam int TIDX_W_DEF = 10;
  localparam int HEIGHT_MAX = 16384;

  localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_SIZE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OUT_WIDTH   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OUT_HEIGHT  = 2'd2;

  typedef enum logic [1:0] {
    FUNC_TAP   = 2'd0,
    FUNC_PIXEL = 2'd1,
    FUNC_START = 2'd2
  } func_e;

  typedef enum logic [1:0] {
    ST_PIXEL  = 2'd0,
    ST_ACCEPT = 2'd1,
    ST_REJECT = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SETUP,
    S_RUN,
    S_DRAIN,
    S_FIN
  } state_e;

  typedef struct packed {
    logic setup;
    logic issue;
    logic tap_we;
    logic pix_we;
  } cell_ctrl_t;

endpackage

[rtl/v2dce_in_if.sv]
// Request channel of the convolution engine.
interface v2dce_in_if #(
  parameter int PIXEL_BITS = 16,
  parameter int TAP_BITS   = 16,
  parameter int TIDX_W     = 10
);
  logic                  valid;
  logic                  ready;
  logic [1:0]            func;
  logic [TIDX_W-1:0]     tap_index;
  logic [TAP_BITS-1:0]   tap_value;
  logic [PIXEL_BITS-1:0] pixel_value;

  modport source (output valid, func, tap_index, tap_value, pixel_value, input ready);
  modport sink   (input valid, func, tap_index, tap_value, pixel_value, output ready);
endinterface

[rtl/v2dce_out_if.sv]
// Result channel of the convolution engine.
interface v2dce_out_if #(
  parameter int PIXEL_BITS = 16
);
  logic                  valid;
  logic                  ready;
  logic [PIXEL_BITS-1:0] out_value;
  logic [10:0]           out_x;
  logic [13:0]           out_y;
  logic [1:0]            status;
  logic                  last;

  modport source (output valid, out_value, out_x, out_y, status, last, input ready);
  modport sink   (input valid, out_value, out_x, out_y, status, last, output ready);
endinterface

[rtl/v2dce_cell.sv]
// MAC cell: one line store row, a kernel copy, a local sum and a link of the sum chain.
module v2dce_cell import v2dce_pkg::*; #(
  parameter int KERNEL_MAX = KERNEL_MAX_DEF,
  parameter int LINE_MAX   = LINE_MAX_DEF,
  parameter int PIXEL_BITS = PIXEL_BITS_DEF,
  parameter int TAP_BITS   = TAP_BITS_DEF,
  parameter int CELL_ID    = 0,
  parameter int KS_W       = $clog2(KERNEL_MAX + 1),
  parameter int KA_W       = $clog2(KERNEL_MAX * KERNEL_MAX + 1),
  parameter int LA_W       = $clog2(LINE_MAX + KERNEL_MAX - 1),
  parameter int ACC_W      = PIXEL_BITS + TAP_BITS + KA_W
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  cell_ctrl_t            ctrl_i,
  input  logic [KS_W-1:0]       ks_i,
  input  logic [KS_W-1:0]       ymod_i,
  input  logic [KS_W-1:0]       j_i,
  input  logic [LA_W-1:0]       raddr_i,
  input  logic [LA_W-1:0]       waddr_i,
  input  logic [KS_W-1:0]       wrow_i,
  input  logic [KA_W-1:0]       tap_addr_i,
  input  logic [TAP_BITS-1:0]   tap_data_i,
  input  logic [PIXEL_BITS-1:0] pix_data_i,
  input  logic [ACC_W-1:0]      psum_i,
  output logic [ACC_W-1:0]      psum_o
);

  localparam int TAPS    = KERNEL_MAX * KERNEL_MAX;
  localparam int ROW_MAX = LINE_MAX + KERNEL_MAX - 1;
  localparam logic [KS_W-1:0] ID = KS_W'(CELL_ID);

  logic [TAP_BITS-1:0]   kmem [TAPS];
  logic [PIXEL_BITS-1:0] lmem [ROW_MAX];

  logic [TAP_BITS-1:0]            kd_q;
  logic [PIXEL_BITS-1:0]          ld_q;
  logic [PIXEL_BITS+TAP_BITS-1:0] prod_q;
  logic [ACC_W-1:0]               acc_q, psum_q;
  logic [KA_W-1:0]                base_q;
  logic                           act_q, v1_q, v2_q;

  logic [KS_W:0]     diff;
  logic [KS_W-1:0]   wi, krow;
  logic [2*KS_W-1:0] base_d;
  logic [KA_W-1:0]   kaddr;

  always_comb begin
    diff = {1'b0, ID} - {1'b0, ymod_i};
    if (diff[KS_W]) begin
      diff = diff + {1'b0, ks_i};
    end
    wi     = diff[KS_W-1:0];
    krow   = ks_i - 1'b1 - wi;
    base_d = krow * ks_i + (2*KS_W)'(ks_i) - 1'b1;
    kaddr  = base_q - KA_W'(j_i);
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.tap_we) begin
      kmem[tap_addr_i] <= tap_data_i;
    end
    if (ctrl_i.issue) begin
      kd_q <= kmem[kaddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.pix_we && wrow_i == ID) begin
      lmem[waddr_i] <= pix_data_i;
    end
    if (ctrl_i.issue) begin
      ld_q <= lmem[raddr_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.setup) begin
      base_q <= base_d[KA_W-1:0];
    end
    prod_q <= ld_q * kd_q;
    psum_q <= psum_i + acc_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q <= 1'b0;
      v1_q  <= 1'b0;
      v2_q  <= 1'b0;
      acc_q <= '0;
    end else begin
      v1_q <= ctrl_i.issue;
      v2_q <= v1_q;
      if (ctrl_i.setup) begin
        act_q <= ID < ks_i;
        acc_q <= '0;
      end else if (v2_q && act_q) begin
        acc_q <= acc_q + ACC_W'(prod_q);
      end
    end
  end

  assign psum_o = psum_q;

endmodule

[rtl/valid_2d_convolution_engine.sv]
// Valid-region 2D convolution engine, top level.
//
// Channels: req (func, tap_index, tap_value, pixel_value) in, rsp (out_value,
// out_x, out_y, status, last) out, both valid/ready; cfg_we_i writes
// kernel_size, out_width, out_height by index, taken at the next start.
// Tap loads, pixels that complete no window and ignored requests stay idle.
// A start answers accepted or rejected in the next cycle.
// A pixel that completes a window runs the setup state, ks column steps through
// the row of KERNEL_MAX MAC cells (each cell reads its line store row and its
// kernel copy once per step), passes the read, product and accumulate
// registers, then the partial sums ripple through the cell chain, one cell a
// cycle, and the result is registered.
// The next request is taken when the engine is idle and the output register
// is free or being emptied; a stalled receiver holds the result and the engine.
// Reset: registers read 1, no frame runs, tap and line stores are undefined
// until written.
module valid_2d_convolution_engine import v2dce_pkg::*; #(
  parameter int KERNEL_MAX = KERNEL_MAX_DEF,
  parameter int LINE_MAX   = LINE_MAX_DEF,
  parameter int PIXEL_BITS = PIXEL_BITS_DEF,
  parameter int TAP_BITS   = TAP_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  v2dce_in_if.sink              req,
  v2dce_out_if.source           rsp
);

  localparam int KS_W    = $clog2(KERNEL_MAX + 1);
  localparam int KA_W    = $clog2(KERNEL_MAX * KERNEL_MAX + 1);
  localparam int LA_W    = $clog2(LINE_MAX + KERNEL_MAX - 1);
  localparam int ACC_W   = PIXEL_BITS + TAP_BITS + KA_W;
  localparam int TAPS    = KERNEL_MAX * KERNEL_MAX;
  localparam int DRAIN_N = KERNEL_MAX + 4;
  localparam int DR_W    = $clog2(DRAIN_N + 1);
  localparam int PW_W    = OW_W + 1;

  state_e state_q, state_d;
  cell_ctrl_t ctrl;

  logic [KS_CFG_W-1:0] ks_q;
  logic [OW_W-1:0]     w_q, cw_q;
  logic [OH_W-1:0]     h_q, ch_q;
  logic [KS_W-1:0]     cks_q, rmod_q, ymod_q, j_q;
  logic [LA_W-1:0]     col_q, x_q;
  logic [OH_W-1:0]     row_q, y_q;
  logic                active_q, last_q;
  logic [DR_W-1:0]     cnt_q;

  logic                  ov_q, olast_q;
  logic [PIXEL_BITS-1:0] oval_q;
  logic [OX_W-1:0]       ox_q;
  logic [OY_W-1:0]       oy_q;
  status_e               ost_q;

  logic acc_req, out_free, is_tap, is_pix, is_start, hit, ok, row_end, x_last, y_last;
  logic [PW_W-1:0]   pw;
  logic [LA_W:0]     col_nx;
  logic [OH_W:0]     row_nx;
  logic [KS_W-1:0]   rmod_nx;
  logic [LA_W-1:0]   x_d;
  logic [OH_W-1:0]   y_d;
  logic [ACC_W:0]    rnd, shr;
  logic [PIXEL_BITS-1:0] pix_res;

  logic [ACC_W-1:0] psum [KERNEL_MAX+1];

  assign out_free = !ov_q || rsp.ready;
  assign acc_req  = req.valid && req.ready;
  assign is_tap   = req.func == FUNC_TAP;
  assign is_pix   = req.func == FUNC_PIXEL;
  assign is_start = req.func == FUNC_START;

  always_comb begin
    ok = ks_q[0] && 32'(ks_q) <= 32'(KERNEL_MAX) && w_q != '0 &&
         32'(w_q) <= 32'(LINE_MAX) && h_q != '0 && 32'(h_q) <= 32'(HEIGHT_MAX);
    pw      = PW_W'(cw_q) + PW_W'(cks_q) - 1'b1;
    col_nx  = {1'b0, col_q} + 1'b1;
    row_nx  = {1'b0, row_q} + 1'b1;
    rmod_nx = (rmod_q + 1'b1 == cks_q) ? '0 : rmod_q + 1'b1;
    hit     = row_nx >= (OH_W+1)'(cks_q) && col_nx >= (LA_W+1)'(cks_q);
    row_end = 32'(col_nx) >= 32'(pw);
    x_d     = col_nx[LA_W-1:0] - LA_W'(cks_q);
    y_d     = row_nx[OH_W-1:0] - OH_W'(cks_q);
    x_last  = 32'(x_d) + 1 == 32'(cw_q);
    y_last  = 32'(y_d) + 1 == 32'(ch_q);
    rnd     = {1'b0, psum[KERNEL_MAX]} + ((ACC_W+1)'(1) << (TAP_BITS - 1));
    shr     = rnd >> TAP_BITS;
    pix_res = (shr > (ACC_W+1)'({PIXEL_BITS{1'b1}})) ? {PIXEL_BITS{1'b1}}
                                                     : shr[PIXEL_BITS-1:0];
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (acc_req && is_pix && active_q && hit) begin
          state_d = S_SETUP;
        end
      end
      S_SETUP: state_d = S_RUN;
      S_RUN: begin
        if (j_q == cks_q - 1'b1) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (cnt_q == DR_W'(DRAIN_N - 1)) begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    req.ready   = 1'b0;
    ctrl        = '0;
    case (state_q)
      S_IDLE: begin
        req.ready   = out_free;
        ctrl.tap_we = acc_req && is_tap && 32'(req.tap_index) < 32'(TAPS);
        ctrl.pix_we = acc_req && is_pix && active_q;
      end
      S_SETUP: ctrl.setup = 1'b1;
      S_RUN:   ctrl.issue = 1'b1;
      default: ctrl = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      ks_q     <= KS_CFG_W'(1);
      w_q      <= OW_W'(1);
      h_q      <= OH_W'(1);
      cks_q    <= KS_W'(1);
      cw_q     <= OW_W'(1);
      ch_q     <= OH_W'(1);
      col_q    <= '0;
      row_q    <= '0;
      rmod_q   <= '0;
      active_q <= 1'b0;
      j_q      <= '0;
      cnt_q    <= '0;
      ov_q     <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_KERNEL_SIZE: ks_q <= cfg_data_i[KS_CFG_W-1:0];
          CFG_OUT_WIDTH:   w_q  <= cfg_data_i[OW_W-1:0];
          CFG_OUT_HEIGHT:  h_q  <= cfg_data_i[OH_W-1:0];
          default: ;
        endcase
      end
      if (ov_q && rsp.ready) begin
        ov_q <= 1'b0;
      end
      if (state_q == S_IDLE && acc_req && is_start) begin
        col_q    <= '0;
        row_q    <= '0;
        rmod_q   <= '0;
        active_q <= ok;
        ov_q     <= 1'b1;
        if (ok) begin
          cks_q <= KS_W'(ks_q);
          cw_q  <= w_q;
          ch_q  <= h_q;
        end
      end
      if (ctrl.pix_we) begin
        if (row_end) begin
          col_q  <= '0;
          row_q  <= row_nx[OH_W-1:0];
          rmod_q <= rmod_nx;
        end else begin
          col_q <= col_nx[LA_W-1:0];
        end
        if (hit && x_last && y_last) begin
          active_q <= 1'b0;
        end
      end
      j_q   <= (state_q == S_RUN) ? j_q + 1'b1 : '0;
      cnt_q <= (state_q == S_DRAIN) ? cnt_q + 1'b1 : '0;
      if (state_q == S_FIN && out_free) begin
        ov_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.pix_we) begin
      x_q    <= x_d;
      y_q    <= y_d;
      ymod_q <= rmod_nx;
      last_q <= x_last && y_last;
    end
    if (state_q == S_IDLE && acc_req && is_start) begin
      oval_q  <= '0;
      ox_q    <= '0;
      oy_q    <= '0;
      olast_q <= 1'b0;
      ost_q   <= ok ? ST_ACCEPT : ST_REJECT;
    end
    if (state_q == S_FIN && out_free) begin
      oval_q  <= pix_res;
      ox_q    <= x_q[OX_W-1:0];
      oy_q    <= y_q[OY_W-1:0];
      olast_q <= last_q;
      ost_q   <= ST_PIXEL;
    end
  end

  assign psum[0] = '0;

  for (genvar c = 0; c < KERNEL_MAX; c++) begin : g_cell
    v2dce_cell #(
      .KERNEL_MAX (KERNEL_MAX),
      .LINE_MAX   (LINE_MAX),
      .PIXEL_BITS (PIXEL_BITS),
      .TAP_BITS   (TAP_BITS),
      .CELL_ID    (c),
      .KS_W       (KS_W),
      .KA_W       (KA_W),
      .LA_W       (LA_W),
      .ACC_W      (ACC_W)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctrl_i     (ctrl),
      .ks_i       (cks_q),
      .ymod_i     (ymod_q),
      .j_i        (j_q),
      .raddr_i    (x_q + LA_W'(j_q)),
      .waddr_i    (col_q),
      .wrow_i     (rmod_q),
      .tap_addr_i (KA_W'(req.tap_index)),
      .tap_data_i (req.tap_value),
      .pix_data_i (req.pixel_value),
      .psum_i     (psum[c]),
      .psum_o     (psum[c+1])
    );
  end

  assign rsp.valid     = ov_q;
  assign rsp.out_value = oval_q;
  assign rsp.out_x     = ox_q;
  assign rsp.out_y     = oy_q;
  assign rsp.status    = ost_q;
  assign rsp.last      = olast_q;

endmodule

[rtl/v2dce_chk.sv]
// Port checker of the convolution engine and its bind.
`include "assert_macros.svh"

module v2dce_chk import v2dce_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid,
  input logic        in_ready,
  input logic [1:0]  in_func,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  out_status,
  input logic        out_last,
  input logic [10:0] out_x
);

  `ASSERT_NEXT(a_hold, clk_i, rst_ni, out_valid && !out_ready, out_valid, "result dropped")
  `ASSERT_NEXT(a_start, clk_i, rst_ni, in_valid && in_ready && in_func == FUNC_START, out_valid && out_status != ST_PIXEL, "start not answered")
  `ASSERT_CLK(a_last, clk_i, rst_ni, out_valid && out_last |-> out_status == ST_PIXEL, "last on status")
  `ASSERT_CLK(a_stat, clk_i, rst_ni, out_valid && out_status != ST_PIXEL |-> out_x == '0 && !out_last, "status payload")

endmodule

bind valid_2d_convolution_engine v2dce_chk u_chk (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid   (req.valid),
  .in_ready   (req.ready),
  .in_func    (req.func),
  .out_valid  (rsp.valid),
  .out_ready  (rsp.ready),
  .out_status (rsp.status),
  .out_last   (rsp.last),
  .out_x      (rsp.out_x)
);
